@@ rtl/gf2pa_pkg.sv @@
`timescale 1ns / 1ps
// shared types and constants of the gf2 polynomial arithmetic unit
package gf2pa_pkg;

	// field widths of the ports
	localparam int WIDTH_DEF = 32;
	localparam int FIELD_W   = 32;
	localparam int OP_W      = 3;
	localparam int STAT_W    = 2;
	localparam int ADDR_W    = 3;

	// modulus after reset: x^8 + x^4 + x^3 + x + 1
	localparam logic [FIELD_W-1:0] MOD_RESET = 32'd283;

	// register index of the modulus
	localparam logic REG_MODULUS = 1'b0;

	// status codes
	localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
	localparam logic [STAT_W-1:0] STAT_NOINV   = 2'd1;
	localparam logic [STAT_W-1:0] STAT_MODZERO = 2'd2;

	// operation codes
	typedef enum logic [OP_W-1:0] {
		OP_ADD = 3'd0,
		OP_MUL = 3'd1,
		OP_INV = 3'd2,
		OP_IRR = 3'd3,
		OP_GCD = 3'd4
	} op_t;

	// sequencer states
	typedef enum logic [2:0] {
		S_IDLE,
		S_RED,
		S_MUL,
		S_GCD,
		S_FIN
	} state_t;

	// control of the shift-and-add cell row
	typedef struct packed {
		logic clr;
		logic en;
		logic fb;
		logic sb;
	} cell_ctrl_t;

endpackage

@@ rtl/gf2_poly_arith_unit_core.sv @@
`timescale 1ns / 1ps
// Top level of the gf2 polynomial arithmetic unit: sequencer, cell row and euclid unit.
// Add and unused codes go straight to the output; multiply reduces operand_a, then multiplies
// by operand_b; inverse reduces operand_a, then runs the euclid unit; gcd runs the euclid unit;
// the irreducible test runs up to n/2 rounds of a squaring and a gcd, n the degree of operand_a.
// One word is in work at a time; the W-cell shift-and-add row and the euclid step set the
// rate. Reset loads modulus 283 and empties the unit; no clearing pass.
module gf2_poly_arith_unit_core
	import gf2pa_pkg::*;
#(
	parameter int WIDTH = WIDTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	// input channel
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [OP_W-1:0]     operation,
	input  logic [FIELD_W-1:0]  operand_a,
	input  logic [FIELD_W-1:0]  operand_b,
	// output channel
	output logic                out_valid,
	input  logic                out_ready,
	output logic [FIELD_W-1:0]  result,
	output logic [STAT_W-1:0]   status,
	// configuration port
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [ADDR_W-1:0]   paddr,
	input  logic [FIELD_W-1:0]  pwdata,
	output logic [FIELD_W-1:0]  prdata,
	output logic                pready
);

	localparam int W  = WIDTH;
	localparam int CW = $clog2(W + 1);

	// highest set bit as a one-hot word
	function automatic logic [W-1:0] top_bit(input logic [W-1:0] v);
		logic [W-1:0] rv, lo, o;
		for (int i = 0; i < W; i++) rv[i] = v[W-1-i];
		lo = rv & (~rv + 1'b1);
		for (int i = 0; i < W; i++) o[i] = lo[W-1-i];
		return o;
	endfunction

	state_t           state_q, state_d;
	op_t              op_q, op_d;
	logic [FIELD_W-1:0] modulus_q;
	logic [W-1:0]     modr_q, modr_d, mtop_q, mtop_d;
	logic [W-1:0]     s_q, s_d, ad_q, ad_d, t_q, t_d, b_q, b_d, icnt_q, icnt_d;
	logic [W-1:0]     res_q, res_d;
	logic [STAT_W-1:0] st_q, st_d;
	logic [CW-1:0]    cnt_q, cnt_d;
	logic             out_valid_q, out_load;
	logic [FIELD_W-1:0] result_q;
	logic [STAT_W-1:0] status_q;
	logic             in_acc, cfg_wr;
	logic [W-1:0]     m_w, a_w, b_w, ptop, mt, r_w, diff, inv_v;
	cell_ctrl_t       cell_ctrl;
	logic             euc_start, euc_done;
	logic [W-1:0]     euc_a, euc_b, euc_va, euc_vb, euc_g, euc_gv;

	// configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready;
	assign prdata = (paddr[2] == REG_MODULUS) ? modulus_q : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q <= MOD_RESET;
		end else if (cfg_wr && paddr[2] == REG_MODULUS) begin
			modulus_q <= pwdata;
		end
	end

	// handshake
	assign in_ready  = (state_q == S_IDLE);
	assign in_acc    = in_valid & in_ready;
	assign out_valid = out_valid_q;
	assign result    = result_q;
	assign status    = status_q;

	// operands at unit width
	assign m_w   = W'(modulus_q);
	assign a_w   = W'(operand_a);
	assign b_w   = W'(operand_b);
	assign mt    = top_bit(m_w);
	assign ptop  = top_bit(a_w);
	assign diff  = r_w ^ W'(2);
	assign inv_v = (|(euc_gv & mtop_q)) ? (euc_gv ^ modr_q) : euc_gv;

	// cell row
	for (genvar i = 0; i < W; i++) begin : g_row
		logic lower;
		if (i == 0) begin : g_first
			assign lower = 1'b0;
		end else begin : g_rest
			assign lower = r_w[i-1];
		end
		gf2pa_cell u_cell (
			.clk    (clk),
			.ctrl   (cell_ctrl),
			.lower  (lower),
			.m_bit  (modr_q[i]),
			.ad_bit (ad_q[i]),
			.r      (r_w[i])
		);
	end

	// euclid unit
	gf2pa_euclid #(.W(W)) u_euclid (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (euc_start),
		.a_in   (euc_a),
		.b_in   (euc_b),
		.va_in  (euc_va),
		.vb_in  (euc_vb),
		.done   (euc_done),
		.g      (euc_g),
		.gv     (euc_gv)
	);

	// sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		op_q   <= op_d;
		modr_q <= modr_d;
		mtop_q <= mtop_d;
		s_q    <= s_d;
		ad_q   <= ad_d;
		t_q    <= t_d;
		b_q    <= b_d;
		icnt_q <= icnt_d;
		cnt_q  <= cnt_d;
		res_q  <= res_d;
		st_q   <= st_d;
		if (out_load) begin
			result_q <= FIELD_W'(res_q);
			status_q <= st_q;
		end
	end

	// next state and controls
	always_comb begin
		state_d   = state_q;
		op_d      = op_q;
		modr_d    = modr_q;
		mtop_d    = mtop_q;
		s_d       = s_q;
		ad_d      = ad_q;
		t_d       = t_q;
		b_d       = b_q;
		icnt_d    = icnt_q;
		cnt_d     = cnt_q;
		res_d     = res_q;
		st_d      = st_q;
		cell_ctrl = '{clr: 1'b0, en: 1'b0, fb: 1'b0, sb: 1'b0};
		euc_start = 1'b0;
		euc_a     = modr_q;
		euc_b     = r_w;
		euc_va    = '0;
		euc_vb    = W'(1);
		out_load  = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (in_acc) begin
					op_d   = op_t'(operation);
					modr_d = m_w;
					mtop_d = mt;
					b_d    = b_w;
					res_d  = '0;
					st_d   = STAT_OK;
					state_d = S_FIN;
					case (operation)
						OP_ADD: begin
							res_d = a_w ^ b_w;
						end
						OP_MUL, OP_INV: begin
							if (m_w == '0) begin
								st_d = STAT_MODZERO;
							end else if (m_w == W'(1)) begin
								st_d = STAT_OK;
							end else if (operation == OP_INV && a_w == '0) begin
								st_d = STAT_OK;
							end else begin
								// reduce operand_a first
								s_d           = a_w;
								ad_d          = W'(1);
								cnt_d         = CW'(W);
								cell_ctrl.clr = 1'b1;
								state_d       = S_RED;
							end
						end
						OP_IRR: begin
							if (ptop == W'(2)) begin
								res_d = W'(1);
							end else if (ptop[W-1:1] != '0) begin
								// square x mod operand_a
								modr_d        = a_w;
								mtop_d        = ptop;
								icnt_d        = ptop >> 2;
								t_d           = W'(2);
								s_d           = W'(2);
								ad_d          = W'(2);
								cnt_d         = CW'(W);
								cell_ctrl.clr = 1'b1;
								state_d       = S_MUL;
							end
						end
						OP_GCD: begin
							euc_start = 1'b1;
							euc_a     = a_w;
							euc_b     = b_w;
							state_d   = S_GCD;
						end
						default: begin
							res_d = '0;
						end
					endcase
				end
			end
			S_RED, S_MUL: begin
				if (cnt_q != '0) begin
					// one horner step
					cell_ctrl.en = 1'b1;
					cell_ctrl.fb = |((r_w << 1) & mtop_q);
					cell_ctrl.sb = s_q[W-1];
					s_d          = s_q << 1;
					cnt_d        = cnt_q - 1'b1;
				end else if (state_q == S_RED) begin
					if (op_q == OP_MUL) begin
						s_d           = b_q;
						ad_d          = r_w;
						cnt_d         = CW'(W);
						cell_ctrl.clr = 1'b1;
						state_d       = S_MUL;
					end else begin
						euc_start = 1'b1;
						state_d   = S_GCD;
					end
				end else if (op_q == OP_MUL) begin
					res_d   = r_w;
					state_d = S_FIN;
				end else begin
					// irreducible round: gcd of operand with x^(2^i) - x
					t_d = r_w;
					if (diff == '0) begin
						res_d   = '0;
						state_d = S_FIN;
					end else begin
						euc_start = 1'b1;
						euc_b     = diff;
						state_d   = S_GCD;
					end
				end
			end
			S_GCD: begin
				if (euc_done) begin
					state_d = S_FIN;
					case (op_q)
						OP_INV: begin
							if (euc_g == W'(1)) begin
								res_d = inv_v;
								st_d  = STAT_OK;
							end else begin
								res_d = '0;
								st_d  = STAT_NOINV;
							end
						end
						OP_IRR: begin
							if (euc_g != W'(1) && euc_g != modr_q) begin
								res_d = '0;
							end else if ((icnt_q >> 2) == '0) begin
								res_d = W'(1);
							end else begin
								icnt_d        = icnt_q >> 2;
								s_d           = t_q;
								ad_d          = t_q;
								cnt_d         = CW'(W);
								cell_ctrl.clr = 1'b1;
								state_d       = S_MUL;
							end
						end
						default: begin
							res_d = euc_g;
						end
					endcase
				end
			end
			S_FIN: begin
				if (!out_valid_q || out_ready) begin
					out_load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

`ifndef SYNTH
	// an inverse result is reduced below the modulus degree
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FIN && op_q == OP_INV) |-> ((res_q & ~(mtop_q - 1'b1)) == '0))
		else $error("inverse not reduced");
	// the irreducible test answers with a single bit
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FIN && op_q == OP_IRR) |-> (res_q[W-1:1] == '0))
		else $error("irreducible test gave a wide result");
	// a pending result is never overwritten
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |-> !out_load)
		else $error("output word overwritten");
	// a status code of three never leaves the unit
	assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> (st_q == STAT_OK || st_q == STAT_NOINV || st_q == STAT_MODZERO))
		else $error("bad status code");
`endif

endmodule

@@ rtl/gf2pa_cell.sv @@
`timescale 1ns / 1ps
// one coefficient cell of the shift-and-add row (times x, reduce, add)
module gf2pa_cell
	import gf2pa_pkg::*;
(
	input  logic       clk,
	input  cell_ctrl_t ctrl,
	input  logic       lower,
	input  logic       m_bit,
	input  logic       ad_bit,
	output logic       r
);

	logic r_q;

	// take the neighbor's bit, fold in modulus and addend
	always_ff @(posedge clk) begin
		if (ctrl.clr) begin
			r_q <= 1'b0;
		end else if (ctrl.en) begin
			r_q <= lower ^ (ctrl.fb & m_bit) ^ (ctrl.sb & ad_bit);
		end
	end

	assign r = r_q;

endmodule

@@ rtl/gf2pa_euclid.sv @@
`timescale 1ns / 1ps
// left-aligned extended euclid unit, one subtract or normalize step per cycle
module gf2pa_euclid
	import gf2pa_pkg::*;
#(
	parameter int W = WIDTH_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [W-1:0] a_in,
	input  logic [W-1:0] b_in,
	input  logic [W-1:0] va_in,
	input  logic [W-1:0] vb_in,
	output logic         done,
	output logic [W-1:0] g,
	output logic [W-1:0] gv
);

	localparam int DW = $clog2(W);

	logic [W-1:0]  a_q, b_q, va_q, vb_q;
	logic [DW-1:0] da_q, db_q;
	logic          busy_q;
	logic          za, zb, na, nb;
	logic [W-1:0]  g_al;
	logic [DW-1:0] gd;

	// zero and normalized flags
	assign za   = ~|a_q;
	assign zb   = ~|b_q;
	assign na   = a_q[W-1];
	assign nb   = b_q[W-1];
	assign done = (za | zb) & (za | na) & (zb | nb);

	// busy flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (start) begin
			busy_q <= 1'b1;
		end else if (done) begin
			busy_q <= 1'b0;
		end
	end

	// step: normalize the unnormalized operands, else subtract the aligned smaller degree
	always_ff @(posedge clk) begin
		if (start) begin
			a_q  <= a_in;
			b_q  <= b_in;
			va_q <= va_in;
			vb_q <= vb_in;
			da_q <= DW'(W - 1);
			db_q <= DW'(W - 1);
		end else if (busy_q && !done) begin
			if ((!za && !na) || (!zb && !nb)) begin
				if (!za && !na) begin
					a_q  <= a_q << 1;
					da_q <= da_q - 1'b1;
				end
				if (!zb && !nb) begin
					b_q  <= b_q << 1;
					db_q <= db_q - 1'b1;
				end
			end else if (da_q >= db_q) begin
				a_q  <= a_q ^ b_q;
				va_q <= va_q ^ (vb_q << (da_q - db_q));
			end else begin
				b_q  <= b_q ^ a_q;
				vb_q <= vb_q ^ (va_q << (db_q - da_q));
			end
		end
	end

	// surviving operand back to its plain position
	assign g_al = zb ? a_q : b_q;
	assign gd   = zb ? da_q : db_q;
	assign gv   = zb ? va_q : vb_q;
	assign g    = g_al >> (DW'(W - 1) - gd);

`ifndef SYNTH
	// a subtract step only happens on two aligned nonzero operands
	assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && !start && !done && na && nb) |=> (!a_q[W-1] || !b_q[W-1]))
		else $error("euclid subtract did not cancel a leading term");
	// the degree of operand a only counts down while running
	assert property (@(posedge clk) disable iff (!arst_n)
		($past(busy_q) && busy_q && !$past(start)) |-> (da_q <= $past(da_q)))
		else $error("euclid degree rose");
	// a finished unit holds its result, also before its first run
	assert property (@(posedge clk) disable iff (!arst_n)
		(!busy_q && !start) |=> ((a_q === $past(a_q)) && (b_q === $past(b_q))))
		else $error("euclid state moved while idle");
`endif

endmodule
